FILE: rtl/core/idq_pkg.sv
// Shared definitions for the indexed deque: sizes, action and status codes,
// controller states, result word layout and the ring index helper.
// No dependencies.
`timescale 1ns / 1ps

package idq_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int POS_W      = 6;
	localparam int ACT_W      = 3;
	// width that holds both a position and a count for compares
	localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_BACK = 3'd0,
		ACT_POP_BACK  = 3'd1,
		ACT_POP_FRONT = 3'd2,
		ACT_GET       = 3'd3,
		ACT_SET       = 3'd4,
		ACT_INSERT    = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SHIFT,
		S_FILL,
		S_RESP
	} state_t;

	typedef struct packed {
		status_t               status;
		logic [DATA_WIDTH-1:0] rdata;
		logic [CNT_W-1:0]      count;
	} result_t;

	typedef struct packed {
		logic                  rd_en;
		logic [IDX_W-1:0]      rd_addr;
		logic                  wr_en;
		logic [IDX_W-1:0]      wr_addr;
		logic [DATA_WIDTH-1:0] wr_data;
	} ram_req_t;

	// ring slot of the entry at offset off from base (off <= DEPTH)
	function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

FILE: rtl/core/idq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module idq_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/idq_ctrl.sv
// Deque sequencer: front and occupancy registers, action decode, ring RAM
// access sequence (including the insert shift loop) and the result word.
// Depends on idq_pkg.
`timescale 1ns / 1ps

module idq_ctrl
	import idq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [ACT_W-1:0]      action,
	input  logic [POS_W-1:0]      position,
	input  logic [DATA_WIDTH-1:0] value,
	output ram_req_t              ram_req,
	input  logic [DATA_WIDTH-1:0] ram_rdata,
	output logic                  res_valid,
	input  logic                  res_ready,
	output result_t               res
);

	state_t                state_q, state_d;
	logic [IDX_W-1:0]      front_q, front_d;
	logic [CNT_W-1:0]      occ_q, occ_d;
	logic [CNT_W-1:0]      idx_q, idx_d;
	logic [CNT_W-1:0]      pos_q, pos_d;
	logic [DATA_WIDTH-1:0] val_q, val_d;
	result_t               res_q, res_d;

	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] occ_ext;
	logic             in_range;
	logic             full;
	logic             empty;
	logic [CNT_W-1:0] pos_off;
	logic [CNT_W-1:0] occ_m1;
	logic [CNT_W-1:0] occ_p1;
	logic [CNT_W-1:0] idx_m1;
	logic [CNT_W-1:0] idx_m2;

	// range and fill checks on the incoming word
	assign pos_ext  = CMP_W'(position);
	assign occ_ext  = CMP_W'(occ_q);
	assign in_range = pos_ext < occ_ext;
	assign pos_off  = pos_ext[CNT_W-1:0];
	assign full     = occ_q == CNT_W'(DEPTH);
	assign empty    = occ_q == '0;
	assign occ_m1   = occ_q - CNT_W'(1);
	assign occ_p1   = occ_q + CNT_W'(1);
	assign idx_m1   = idx_q - CNT_W'(1);
	assign idx_m2   = idx_q - CNT_W'(2);

	assign req_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_RESP;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			occ_q   <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		pos_q <= pos_d;
		val_q <= val_d;
		res_q <= res_d;
	end

	// next state, ring RAM requests and result word
	always_comb begin
		state_d = state_q;
		front_d = front_q;
		occ_d   = occ_q;
		idx_d   = idx_q;
		pos_d   = pos_q;
		val_d   = val_q;
		res_d   = res_q;
		ram_req = '0;

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					res_d   = '{status: ST_OK, rdata: '0, count: occ_q};
					state_d = S_RESP;
					case (action)
						ACT_PUSH_BACK: begin
							if (full) begin
								res_d.status = ST_FULL;
							end else begin
								ram_req.wr_en   = 1'b1;
								ram_req.wr_addr = ring_idx(front_q, occ_q);
								ram_req.wr_data = value;
								occ_d           = occ_p1;
								res_d.count     = occ_p1;
							end
						end
						ACT_POP_BACK: begin
							if (empty) begin
								res_d.status = ST_EMPTY;
							end else begin
								ram_req.rd_en   = 1'b1;
								ram_req.rd_addr = ring_idx(front_q, occ_m1);
								occ_d           = occ_m1;
								state_d         = S_READ;
							end
						end
						ACT_POP_FRONT: begin
							if (empty) begin
								res_d.status = ST_EMPTY;
							end else begin
								ram_req.rd_en   = 1'b1;
								ram_req.rd_addr = front_q;
								front_d         = ring_idx(front_q, CNT_W'(1));
								occ_d           = occ_m1;
								state_d         = S_READ;
							end
						end
						ACT_GET: begin
							if (!in_range) begin
								res_d.status = ST_RANGE;
							end else begin
								ram_req.rd_en   = 1'b1;
								ram_req.rd_addr = ring_idx(front_q, pos_off);
								state_d         = S_READ;
							end
						end
						ACT_SET: begin
							if (!in_range) begin
								res_d.status = ST_RANGE;
							end else begin
								ram_req.wr_en   = 1'b1;
								ram_req.wr_addr = ring_idx(front_q, pos_off);
								ram_req.wr_data = value;
							end
						end
						ACT_INSERT: begin
							if (full) begin
								res_d.status = ST_FULL;
							end else if (!in_range) begin
								res_d.status = ST_RANGE;
							end else begin
								// start the shift with the last entry
								ram_req.rd_en   = 1'b1;
								ram_req.rd_addr = ring_idx(front_q, occ_m1);
								idx_d           = occ_q;
								pos_d           = pos_off;
								val_d           = value;
								state_d         = S_SHIFT;
							end
						end
						default: begin
							res_d.status = ST_RANGE;
						end
					endcase
				end
			end
			S_READ: begin
				res_d   = '{status: ST_OK, rdata: ram_rdata, count: occ_q};
				state_d = S_RESP;
			end
			S_SHIFT: begin
				// move entry idx-1 to idx, fetch idx-2 while still above pos
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = ring_idx(front_q, idx_q);
				ram_req.wr_data = ram_rdata;
				idx_d           = idx_m1;
				if (idx_m1 > pos_q) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = ring_idx(front_q, idx_m2);
				end else begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = ring_idx(front_q, pos_q);
				ram_req.wr_data = val_q;
				occ_d           = occ_p1;
				res_d           = '{status: ST_OK, rdata: '0, count: occ_p1};
				state_d         = S_RESP;
			end
			S_RESP: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// occupancy never passes the ring size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	// shift loop never reads the slot it writes in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.rd_en && ram_req.wr_en |-> ram_req.rd_addr != ram_req.wr_addr)
		else $error("read and write to the same slot");

	// the shift loop is entered only from idle or from itself
	a_shift_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> $past(state_q) == S_IDLE || $past(state_q) == S_SHIFT)
		else $error("shift entered from wrong state");

	// a result word holds steady while it waits for the output register
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_q))
		else $error("result changed while stalled");

endmodule

FILE: rtl/core/indexed_deque.sv
// Indexed deque top level: ring RAM, sequencer and the output register.
// Depends on idq_pkg, idq_ram and idq_ctrl.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one word: action, position
//   and value. Response channel (rsp_valid/rsp_ready) returns one word per
//   request: status, read_value and entry_count, in request order.
//   One request is worked at a time; req_ready is high while the sequencer
//   is idle. The output register lets the next request in while a response
//   word waits for the receiver.
//   Steps per request, set by the single-port-per-direction ring RAM with
//   its registered read:
//     push, set and any refused action: straight to the response
//     pop back, pop front, get:         one RAM read, then the response
//     insert:                           (count - position) shifts, one shifted
//                                       entry per cycle, then the new value
//   The response word shows in the cycle after the sequencer hands it over.
//   Reset empties the queue (front and count cleared); the RAM needs no
//   clearing, since only written slots are ever read.
//   If the receiver stalls, the response word holds in the output register,
//   one more result waits in the sequencer, and requests are refused after.
`timescale 1ns / 1ps

module indexed_deque
	import idq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [ACT_W-1:0]      action,
	input  logic [POS_W-1:0]      position,
	input  logic [DATA_WIDTH-1:0] value,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic [1:0]            status,
	output logic [DATA_WIDTH-1:0] read_value,
	output logic [CNT_W-1:0]      entry_count
);

	ram_req_t              ram_req;
	logic [DATA_WIDTH-1:0] ram_rdata;
	logic                  res_valid;
	logic                  res_ready;
	result_t               res;

	logic                  out_valid_q;
	result_t               out_q;

	idq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.action    (action),
		.position  (position),
		.value     (value),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	idq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (ram_rdata)
	);

	// output register: loads when empty or being drained
	assign res_ready = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign status      = out_q.status;
	assign read_value  = out_q.rdata;
	assign entry_count = out_q.count;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for indexed_deque: random valid/ready traffic on both channels,
// with every response word checked against a behavioral deque model.
// Depends on idq_pkg and the indexed_deque RTL.
`timescale 1ns / 1ps

module tb_top;
	import idq_pkg::*;

	localparam int unsigned RANDOM_WORDS = 1450;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	// worst insert shifts DEPTH - 1 entries, plus the output register
	localparam int unsigned DRAIN_CYCLES = DEPTH + 16;
	localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

	// Behavioral deque plus the list of response words still owed by the DUT
	class deque_scoreboard;
		logic [DATA_WIDTH-1:0] ring [DEPTH];
		int unsigned head;
		int unsigned occupancy;
		result_t due_responses [$];
		int unsigned errors;
		int unsigned checked;
		int unsigned peak;
		int unsigned full_refusals;

		function new();
			head = 0;
			occupancy = 0;
			errors = 0;
			checked = 0;
			peak = 0;
			full_refusals = 0;
		endfunction

		function int unsigned slot(input int unsigned off);
			return (head + off) % DEPTH;
		endfunction

		// apply one accepted request word and queue the response it must produce
		function void note_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
			input logic [DATA_WIDTH-1:0] val);
			result_t r;
			int unsigned p;
			p = pos;
			r.status = ST_OK;
			r.rdata = '0;
			case (act)
			ACT_PUSH_BACK: begin
				if (occupancy >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					ring[slot(occupancy)] = val;
					occupancy++;
				end
			end
			ACT_POP_BACK: begin
				if (occupancy == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.rdata = ring[slot(occupancy - 1)];
					occupancy--;
				end
			end
			ACT_POP_FRONT: begin
				if (occupancy == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.rdata = ring[slot(0)];
					head = slot(1);
					occupancy--;
				end
			end
			ACT_GET: begin
				if (p >= occupancy) r.status = ST_RANGE;
				else r.rdata = ring[slot(p)];
			end
			ACT_SET: begin
				if (p >= occupancy) r.status = ST_RANGE;
				else ring[slot(p)] = val;
			end
			ACT_INSERT: begin
				if (occupancy >= DEPTH) begin
					r.status = ST_FULL;
				end else if (p >= occupancy) begin
					r.status = ST_RANGE;
				end else begin
					for (int unsigned i = occupancy; i > p; i--) begin
						ring[slot(i)] = ring[slot(i - 1)];
					end
					ring[slot(p)] = val;
					occupancy++;
				end
			end
			default: begin
				r.status = ST_RANGE;
			end
			endcase
			if (r.status != ST_OK) r.rdata = '0;
			if (r.status == ST_FULL) full_refusals++;
			if (occupancy > peak) peak = occupancy;
			r.count = CNT_W'(occupancy);
			due_responses.push_back(r);
		endfunction

		// compare one accepted response word with the oldest owed one
		function void check_response(input logic [1:0] st, input logic [DATA_WIDTH-1:0] rd,
			input logic [CNT_W-1:0] cnt);
			result_t want;
			if (due_responses.size() == 0) begin
				$error("response word with no request outstanding");
				errors++;
				return;
			end
			want = due_responses.pop_front();
			checked++;
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				errors++;
			end
			if (rd !== want.rdata) begin
				$error("read_value: expected %h, got %h", want.rdata, rd);
				errors++;
			end
			if (cnt !== want.count) begin
				$error("entry_count: expected %0d, got %0d", want.count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	logic [ACT_W-1:0]      action = '0;
	logic [POS_W-1:0]      position = '0;
	logic [DATA_WIDTH-1:0] value = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	logic [1:0]            status;
	logic [DATA_WIDTH-1:0] read_value;
	logic [CNT_W-1:0]      entry_count;

	deque_scoreboard sb;
	bit              quiet = 1'b0;
	int unsigned     sent = 0;
	int unsigned     cycles = 0;

	indexed_deque dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.action      (action),
		.position    (position),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.read_value  (read_value),
		.entry_count (entry_count)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("indexed_deque verification failed");
			$finish;
		end
	end

	// idle cycles for one word; none during quiet stretches
	function automatic int unsigned draw_gap();
		return quiet ? 0 : $urandom_range(0, 12);
	endfunction

	// position inside the live range (edges favored) or past the count
	function automatic logic [POS_W-1:0] pick_position(input bit in_range);
		int unsigned occ;
		occ = sb.occupancy;
		if (occ != 0 && (in_range || occ >= DEPTH)) begin
			case ($urandom_range(0, 4))
			0: return '0;
			1: return POS_W'(occ - 1);
			default: return POS_W'($urandom_range(0, occ - 1));
			endcase
		end
		return POS_W'($urandom_range(occ, DEPTH - 1));
	endfunction

	// drive one request word and hold it until accepted
	task automatic send_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
		input logic [DATA_WIDTH-1:0] val);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		position <= pos;
		value <= val;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note_request(act, pos, val);
		sent++;
	endtask

	// general traffic with mostly in-range positions
	task automatic run_mixed(input int unsigned n);
		int unsigned pick;
		bit in_range;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			in_range = ($urandom_range(0, 99) < 88);
			if (pick < 25) send_request(ACT_PUSH_BACK, pick_position(in_range), $urandom());
			else if (pick < 37) send_request(ACT_POP_BACK, pick_position(in_range), $urandom());
			else if (pick < 49) send_request(ACT_POP_FRONT, pick_position(in_range), $urandom());
			else if (pick < 67) send_request(ACT_GET, pick_position(in_range), $urandom());
			else if (pick < 80) send_request(ACT_SET, pick_position(in_range), $urandom());
			else if (pick < 98) send_request(ACT_INSERT, pick_position(in_range), $urandom());
			else if (pick == 98) send_request(ACT_SPARE_LO, pick_position(in_range), $urandom());
			else send_request(ACT_SPARE_HI, pick_position(in_range), $urandom());
		end
	endtask

	// grow to full, then knock on the full queue
	task automatic run_fill();
		int unsigned pick;
		while (sb.occupancy < DEPTH) begin
			pick = $urandom_range(0, 99);
			if (pick < 70 || sb.occupancy == 0)
				send_request(ACT_PUSH_BACK, pick_position(1'b1), $urandom());
			else if (pick < 85)
				send_request(ACT_INSERT, pick_position(1'b1), $urandom());
			else if (pick < 93)
				send_request(ACT_GET, pick_position(1'b1), $urandom());
			else
				send_request(ACT_SET, pick_position(1'b1), $urandom());
		end
		send_request(ACT_PUSH_BACK, pick_position(1'b1), $urandom());
		send_request(ACT_INSERT, pick_position(1'b1), $urandom());
		send_request(ACT_GET, POS_W'(DEPTH - 1), $urandom());
		send_request(ACT_INSERT, '0, $urandom());
	endtask

	// shrink to empty from both ends, then pop the empty queue
	task automatic run_drain();
		int unsigned pick;
		while (sb.occupancy != 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) send_request(ACT_POP_BACK, pick_position(1'b1), $urandom());
			else if (pick < 90) send_request(ACT_POP_FRONT, pick_position(1'b1), $urandom());
			else send_request(ACT_GET, pick_position(1'b1), $urandom());
		end
		send_request(ACT_POP_FRONT, pick_position(1'b0), $urandom());
		send_request(ACT_POP_BACK, pick_position(1'b0), $urandom());
	endtask

	// receiver: random stall before each response word
	initial begin
		int unsigned stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(status, read_value, entry_count);
	end

	// stimulus and end of run
	initial begin
		int unsigned directed;
		int unsigned episode;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// refusals on the empty queue and the spare action codes
		send_request(ACT_POP_BACK, '0, 32'h0);
		send_request(ACT_POP_FRONT, '0, 32'h0);
		send_request(ACT_GET, '0, 32'h0);
		send_request(ACT_SET, 6'd5, 32'hFFFF_FFFF);
		send_request(ACT_INSERT, '0, 32'h1234_5678);
		send_request(ACT_SPARE_LO, 6'd63, 32'hFFFF_FFFF);
		send_request(ACT_SPARE_HI, '0, 32'h0);
		// data extremes, indexed access at the edges of the live range
		send_request(ACT_PUSH_BACK, '0, 32'h0000_0000);
		send_request(ACT_PUSH_BACK, 6'd63, 32'hFFFF_FFFF);
		send_request(ACT_PUSH_BACK, '0, 32'hA5A5_A5A5);
		send_request(ACT_GET, 6'd63, 32'h0);
		send_request(ACT_GET, 6'd2, 32'h0);
		send_request(ACT_SET, 6'd1, 32'h5A5A_5A5A);
		send_request(ACT_INSERT, '0, 32'h8000_0001);
		send_request(ACT_INSERT, 6'd3, 32'h7FFF_FFFE);
		send_request(ACT_INSERT, 6'd5, 32'hDEAD_BEEF);
		send_request(ACT_GET, 6'd1, 32'h0);
		// drain through the single-entry pop
		send_request(ACT_POP_FRONT, '0, 32'h0);
		send_request(ACT_POP_BACK, '0, 32'h0);
		send_request(ACT_POP_BACK, '0, 32'h0);
		send_request(ACT_POP_FRONT, '0, 32'h0);
		send_request(ACT_POP_FRONT, '0, 32'h0);
		send_request(ACT_GET, '0, 32'h0);
		send_request(ACT_POP_BACK, '0, 32'h0);
		directed = sent;

		// random episodes, some with no idling at all
		while (sent < directed + RANDOM_WORDS) begin
			quiet = ($urandom_range(0, 4) == 0);
			episode = $urandom_range(0, 9);
			if (episode < 2) run_fill();
			else if (episode < 4) run_drain();
			else run_mixed($urandom_range(20, 60));
		end
		quiet = 1'b0;
		req_valid <= 1'b0;

		while (sb.due_responses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d request words sent, %0d response words compared", sent, sb.checked);
		$display("peak occupancy %0d of %0d, %0d refusals on a full queue",
			sb.peak, DEPTH, sb.full_refusals);
		if (sb.errors == 0) begin
			$display("indexed_deque verification clean");
		end else begin
			$display("indexed_deque verification failed");
		end
		$finish;
	end

endmodule
